// ===== hw/rtl/mlpq_pkg.sv =====
// shared types and constants for the multi-level priority queue
`timescale 1ns / 1ps

package mlpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ENQUEUED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEQUEUED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic enq;       // enqueue beat accepted
    logic deq;       // dequeue beat accepted
    logic load_rd;   // capture slot read data into the result register
  } mlpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_valid;     // result register holds a beat
    logic any_nonempty;  // at least one level holds an entry
  } mlpq_stat_t;

endpackage

// ===== hw/rtl/mlpq_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps

interface mlpq_req_if
  import mlpq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [VALUE_W-1:0] value;
  logic        [PRIO_W-1:0]  priority_req;

  modport source (output valid, output func, output value, output priority_req,
                  input ready);
  modport sink   (input valid, input func, input value, input priority_req,
                  output ready);
endinterface

interface mlpq_rsp_if
  import mlpq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic        [STAT_W-1:0]  status;

  modport source (output valid, output out_value, output status, input ready);
  modport sink   (input valid, input out_value, input status, output ready);
endinterface

// ===== hw/rtl/mlpq_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mlpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mlpq_ctrl.sv =====
// controller: handshake and sequencing of one operation at a time
`timescale 1ns / 1ps

module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_ready,
  input  logic       out_ready,
  input  mlpq_stat_t stat,
  output mlpq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   res_free;

  assign res_free = !stat.res_valid || out_ready;
  assign in_ready = (state == S_IDLE) && res_free;
  assign accept   = in_valid && in_ready;

  assign cmd.enq     = accept && (in_func == FUNC_ENQ);
  assign cmd.deq     = accept && (in_func == FUNC_DEQ);
  assign cmd.load_rd = (state == S_READ) && res_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        // a dequeue with data waits in S_READ for the registered slot read
        if (cmd.deq && stat.any_nonempty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (cmd.load_rd) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/mlpq_dp.sv =====
// datapath: level pointers, slot storage, capacity register, result register
`timescale 1ns / 1ps

module mlpq_dp
  import mlpq_pkg::*;
#(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned DEPTH  = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_data,
  input  mlpq_cmd_t                 cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [PRIO_W-1:0]         in_prio,
  input  logic                      out_ready,
  output mlpq_stat_t                stat,
  output logic signed [VALUE_W-1:0] res_value,
  output logic [STAT_W-1:0]         res_status
);

  localparam int unsigned PW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned LW   = $clog2(LEVELS);
  localparam int unsigned CW   = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned RAMD = LEVELS * (2 ** IW);

  logic [CFG_W-1:0] level_capacity;
  logic [PW-1:0]    front [LEVELS];
  logic [PW-1:0]    rear  [LEVELS];
  logic             res_valid;

  logic [CW-1:0]     cap_eff;
  logic [LEVELS-1:0] nonempty;
  logic [LEVELS-1:0] full;
  logic [LEVELS-1:0] grant;
  logic [LEVELS-1:0] enq_hit;
  logic              lvl_ok;
  logic [LW-1:0]     lvl_idx;
  logic              enq_full;
  logic              enq_do;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [LW-1:0]     grant_idx;
  logic [VALUE_W-1:0] rd_data;

  // capacity above the physical depth is clamped
  always_comb begin
    if (CW'(level_capacity) > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(level_capacity);
    end
  end

  assign lvl_ok  = 32'(in_prio) < LEVELS;
  assign lvl_idx = LW'(in_prio);

  // per-level lanes
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      nonempty[l] = front[l] < rear[l];
      full[l]     = CW'(rear[l]) >= cap_eff;
      enq_hit[l]  = lvl_ok && (lvl_idx == LW'(l));
    end
  end

  // lowest-numbered non-empty level wins
  assign grant = nonempty & (~nonempty + LEVELS'(1));

  always_comb begin
    enq_full  = !lvl_ok;
    wr_ptr    = '0;
    rd_ptr    = '0;
    grant_idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (enq_hit[l]) begin
        enq_full = full[l];
        wr_ptr   = rear[l];
      end
      if (grant[l]) begin
        rd_ptr    = front[l];
        grant_idx = LW'(l);
      end
    end
  end

  assign enq_do = cmd.enq && !enq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        front[l] <= '0;
        rear[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (enq_do && enq_hit[l]) begin
          rear[l] <= rear[l] + PW'(1);
        end else if (cmd.deq && grant[l]) begin
          // level drained: reclaim all of its slots
          if (front[l] + PW'(1) >= rear[l]) begin
            front[l] <= '0;
            rear[l]  <= '0;
          end else begin
            front[l] <= front[l] + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      level_capacity <= cfg_data;
    end
  end

  mlpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (RAMD)
  ) u_slots (
    .clk   (clk),
    .we    (enq_do),
    .waddr ({lvl_idx, wr_ptr[IW-1:0]}),
    .wdata (in_value),
    .re    (cmd.deq && (nonempty != '0)),
    .raddr ({grant_idx, rd_ptr[IW-1:0]}),
    .rdata (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.enq || cmd.load_rd || (cmd.deq && (nonempty == '0))) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      res_value  <= '0;
      res_status <= enq_full ? ST_FULL : ST_ENQUEUED;
    end else if (cmd.deq && (nonempty == '0)) begin
      res_value  <= '0;
      res_status <= ST_UNDERFLOW;
    end else if (cmd.load_rd) begin
      res_value  <= rd_data;
      res_status <= ST_DEQUEUED;
    end
  end

  assign stat.res_valid    = res_valid;
  assign stat.any_nonempty = nonempty != '0;

endmodule

// ===== hw/rtl/multi_level_priority_queue.sv =====
// top level of the multi-level priority queue
`timescale 1ns / 1ps

// LEVELS linear queues, one per priority level, DEPTH slots each, held in one
// ram addressed by level and slot. an enqueue beat appends to its level unless
// that level's write pointer has reached level_capacity (clamped to DEPTH) or
// the level does not exist, in which case status is level full. a dequeue beat
// takes the front of the lowest-numbered non-empty level, or reports underflow
// when all are empty; out_value is zero for anything but a dequeue. a level's
// slots are only reclaimed once it drains completely. one operation is in
// flight at a time: enqueue and underflow results are registered at the edge
// that takes the request; a dequeue with data is loaded in S_READ from the
// registered read of the slot ram. the next request is taken in S_IDLE once
// the result register is empty or its beat is being taken in the same cycle.
// level_capacity may only be written while no operation is in flight.

module multi_level_priority_queue
  import mlpq_pkg::*;
#(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned DEPTH  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  mlpq_req_if.sink         req,
  mlpq_rsp_if.source       rsp
);

  mlpq_cmd_t  cmd;
  mlpq_stat_t stat;

  // sequencing of each request beat
  mlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pointers, storage and the result register
  mlpq_dp #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .in_value   (req.value),
    .in_prio    (req.priority_req),
    .out_ready  (rsp.ready),
    .stat       (stat),
    .res_value  (rsp.out_value),
    .res_status (rsp.status)
  );

  // response beat is valid whenever the result register is loaded
  assign rsp.valid = stat.res_valid;

endmodule
